// ===== hdl/ibaif_pkg.sv =====
// ----------------------------------------------------------------------------
// ibaif_pkg
// Shared types, constants and helpers for the IMU batch average IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none
package ibaif_pkg;

  localparam int unsigned NumAxes   = 6;
  localparam int unsigned MaxBatch  = 128;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned CntW      = $clog2(MaxBatch + 1);
  localparam int unsigned SumW      = 16 + $clog2(MaxBatch + 1);
  localparam int unsigned DivW      = SumW + FracBits;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_POLL_END = 2'd1,
    OP_OVERFLOW = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_NO_DATA  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_ALPHA   = 3'd0,
    REG_BIAS_EN = 3'd1,
    REG_BIAS_AX = 3'd2,
    REG_BIAS_AY = 3'd3,
    REG_BIAS_AZ = 3'd4,
    REG_BIAS_GX = 3'd5,
    REG_BIAS_GY = 3'd6,
    REG_BIAS_GZ = 3'd7
  } reg_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         sample_count;
    logic signed [23:0] out_accel_x;
    logic signed [23:0] out_accel_y;
    logic signed [23:0] out_accel_z;
    logic signed [23:0] out_gyro_x;
    logic signed [23:0] out_gyro_y;
    logic signed [23:0] out_gyro_z;
  } out_item_t;

  // lane control from the sequencer
  typedef struct packed {
    logic       start;    // begin divide
    logic       seeded;   // filter already seeded
    logic       bias_en;
    logic [8:0] alpha;    // clamped to 256
  } lane_ctrl_t;

  function automatic logic signed [23:0] sat24(input logic signed [DivW+1:0] v);
    if (v > $signed({{(DivW-22){1'b0}}, 24'h7FFFFF})) return 24'sh7FFFFF;
    if (v < $signed({{(DivW-22){1'b1}}, 24'h800000})) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ibaif_lane.sv =====
// ----------------------------------------------------------------------------
// ibaif_lane
// One axis: sum accumulator, restoring divider, bias and IIR filter state.
// ----------------------------------------------------------------------------
`default_nettype none
module ibaif_lane import ibaif_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clear_i,
  input  wire logic               add_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic [CntW-1:0]    count_i,
  input  wire lane_ctrl_t         ctrl_i,
  input  wire logic signed [23:0] bias_i,
  output logic                    done_o,
  output logic signed [23:0]      y_o
);

  localparam int unsigned StepW = $clog2(DivW + 1);

  logic signed [SumW-1:0] sum_q;
  logic signed [23:0]     state_q;
  logic [DivW-1:0]        quo_q;
  logic [CntW-1:0]        rem_q;
  logic [StepW-1:0]       step_q;
  logic                   busy_q, neg_q, filt_q, done_q;
  logic signed [DivW+1:0] x_q;
  logic signed [23:0]     xs;
  logic [CntW:0]          rem_sh;
  logic                   ge;
  logic [DivW-1:0]        quo_nx;
  logic signed [DivW+1:0] xv;
  logic signed [33:0]     t;

  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, count_i};
  assign quo_nx = {quo_q[DivW-2:0], ge};
  assign xv     = neg_q ? -$signed({2'b0, quo_nx}) : $signed({2'b0, quo_nx});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      state_q <= '0;
      busy_q  <= 1'b0;
      filt_q  <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= filt_q;
      filt_q <= busy_q && (step_q == StepW'(DivW - 1));
      if (clear_i) begin
        sum_q <= '0;
      end else if (add_i) begin
        sum_q <= sum_q + SumW'(sample_i);
      end
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(DivW - 1)) begin
          busy_q <= 1'b0;
        end
      end
      if (filt_q) begin
        state_q <= ctrl_i.seeded ? y_o : xs;
      end
    end
  end

  // restoring divide of |sum| << FracBits, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      neg_q <= sum_q[SumW-1];
      quo_q <= DivW'(sum_q[SumW-1] ? -sum_q : sum_q) << FracBits;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? CntW'(rem_sh - {1'b0, count_i}) : rem_sh[CntW-1:0];
      quo_q <= quo_nx;
      if (step_q == StepW'(DivW - 1)) begin
        x_q <= ctrl_i.bias_en ? xv - (DivW+2)'(bias_i) : xv;
      end
    end
  end

  assign xs = sat24(x_q);
  // arithmetic shift floors toward minus infinity
  assign t  = $signed({1'b0, ctrl_i.alpha}) * xs
            + $signed({1'b0, 9'd256 - ctrl_i.alpha}) * state_q;

  always_comb begin
    y_o = filt_q ? (ctrl_i.seeded ? t[31:8] : xs) : state_q;
  end
  assign done_o = done_q;

  a_done_after_filt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filt_q |=> done_q) else $error("done missing");
  a_no_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> busy_q) else $error("divider not started");
  a_busy_no_filt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !filt_q) else $error("filter during divide");

endmodule
`default_nettype wire

// ===== hdl/imu_batch_average_iir_filter.sv =====
// ----------------------------------------------------------------------------
// imu_batch_average_iir_filter
// Six-lane batch averager with per-axis first-order IIR lowpass.
// ----------------------------------------------------------------------------
// Sample and overflow transactions and ignored op codes need no divide.
// A poll-end with data runs a 32-step bit-serial divider in every lane,
// then the filter update and the output register. An empty poll-end needs no divide.
// One transaction is in work at a time.
// Reset clears sums, count, filter states and seeded flag, and restores config defaults.
`default_nettype none
module imu_batch_average_iir_filter import ibaif_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [8:0]         alpha_q;
  logic               bias_en_q;
  logic signed [23:0] bias_q [NumAxes];
  logic [CntW-1:0]    count_q;
  logic               seeded_q, busy_q, out_valid_q;
  out_item_t          out_q;
  logic               acc, add, clr;
  lane_ctrl_t         ctrl;
  logic [NumAxes-1:0] done;
  logic signed [23:0] y [NumAxes];
  logic signed [15:0] smp [NumAxes];
  op_e                op;

  assign op   = op_e'(in_data_i.op);
  assign in_ready_o = !busy_q && !out_valid_q;
  assign acc  = in_valid_i && in_ready_o;
  assign add  = acc && op == OP_SAMPLE && count_q < CntW'(MaxBatch);
  assign clr  = acc && op == OP_OVERFLOW || (busy_q && done[0]);
  assign ctrl.start   = acc && op == OP_POLL_END && count_q != '0;
  assign ctrl.seeded  = seeded_q;
  assign ctrl.bias_en = bias_en_q;
  assign ctrl.alpha   = alpha_q > 9'd256 ? 9'd256 : alpha_q;

  assign smp[0] = in_data_i.accel_x;
  assign smp[1] = in_data_i.accel_y;
  assign smp[2] = in_data_i.accel_z;
  assign smp[3] = in_data_i.gyro_x;
  assign smp[4] = in_data_i.gyro_y;
  assign smp[5] = in_data_i.gyro_z;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    ibaif_lane u_lane (
      .clk_i, .rst_ni, .clear_i(clr), .add_i(add), .sample_i(smp[g]),
      .count_i(count_q), .ctrl_i(ctrl), .bias_i(bias_q[g]),
      .done_o(done[g]), .y_o(y[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= 9'd205;
      bias_en_q   <= 1'b0;
      for (int i = 0; i < NumAxes; i++) bias_q[i] <= '0;
      count_q     <= '0;
      seeded_q    <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_ALPHA:   alpha_q   <= cfg_data_i[8:0];
          REG_BIAS_EN: bias_en_q <= cfg_data_i[0];
          default:     bias_q[cfg_idx_i - CfgIdxW'(REG_BIAS_AX)] <= cfg_data_i;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (clr) count_q <= '0;
      else if (add) count_q <= count_q + 1'b1;
      if (ctrl.start) busy_q <= 1'b1;
      if (acc && (op == OP_OVERFLOW || (op == OP_POLL_END && count_q == '0))) begin
        out_valid_q <= 1'b1;
      end
      if (busy_q && done[0]) begin
        busy_q      <= 1'b0;
        seeded_q    <= 1'b1;
        out_valid_q <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (acc && op == OP_OVERFLOW) begin
      out_q <= '{status: ST_OVERFLOW, default: '0};
    end else if (acc && op == OP_POLL_END && count_q == '0) begin
      out_q <= '{status: ST_NO_DATA, default: '0};
    end else if (busy_q && done[0]) begin
      out_q.status       <= ST_VALID;
      out_q.sample_count <= count_q > CntW'(255) ? 8'd255 : 8'(count_q);
      out_q.out_accel_x  <= y[0];
      out_q.out_accel_y  <= y[1];
      out_q.out_accel_z  <= y[2];
      out_q.out_gyro_x   <= y[3];
      out_q.out_gyro_y   <= y[4];
      out_q.out_gyro_z   <= y[5];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_lanes_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done[0] |-> &done) else $error("lanes out of step");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o) else $error("accept while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxBatch)) else $error("count above batch size");
  a_seed_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && done[0]) |=> seeded_q && out_valid_q) else $error("no result");

endmodule
`default_nettype wire
